>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the converter's checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge except while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/b2yuv_pkg.sv
// ----------------------------------------------------------------------------
// b2yuv_pkg
// Types, fixed-point coefficients and register codes of the BGR to YUV 4:2:0
// converter.
// ----------------------------------------------------------------------------
package b2yuv_pkg;

   localparam int PIX_W        = 8;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam int CHROMA_IDX_W = 11;
   localparam int SUM_W        = 9;
   localparam int ENTRY_W      = 2 * SUM_W;
   localparam int PROD_W       = 26;
   localparam int FRAC_BITS    = 16;
   localparam int Q_W          = PROD_W - FRAC_BITS;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET = 13'd480;

   // Q0.16 coefficients. The U and V coefficients named negative are subtracted.
   localparam int Y_R = 19595;
   localparam int Y_G = 38470;
   localparam int Y_B = 7471;
   localparam int U_R = 11076;
   localparam int U_G = 21692;
   localparam int U_B = 32702;
   localparam int V_R = 32702;
   localparam int V_G = 27460;
   localparam int V_B = 5308;
   localparam int CHROMA_OFFSET = 128 * 65536;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pixel_type;

   // Classification of one pixel, worked out by the front end.
   typedef struct packed {
      logic                    frame_end;
      logic                    emit;
      logic                    store_wr;
      logic                    use_store;
      logic                    odd_col;
      logic [1:0]              chroma_shift;
      logic [CHROMA_IDX_W-1:0] chroma_column;
      logic [CHROMA_IDX_W-1:0] chroma_row;
   } ctrl_type;

   // Fixed-point chroma sum to a byte clamped to 0..255.
   function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [PROD_W-1:0] s);
      logic [Q_W-1:0] q;
      q = s[PROD_W-1:FRAC_BITS];
      if (s[PROD_W-1] || (s == '0)) begin
         return '0;
      end else if (q > Q_W'(255)) begin
         return '1;
      end else begin
         return q[PIX_W-1:0];
      end
   endfunction

endpackage

>>> hdl/b2yuv_ram.sv
// ----------------------------------------------------------------------------
// b2yuv_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module b2yuv_ram #(
   parameter  int WIDTH  = 18,
   parameter  int DEPTH  = 2048,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/b2yuv_front.sv
// ----------------------------------------------------------------------------
// b2yuv_front
// Size registers, pixel position counters and per-pixel classification.
// ----------------------------------------------------------------------------
module b2yuv_front #(
   parameter  int MAX_WIDTH  = 4096,
   parameter  int MAX_HEIGHT = 4096,
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2,
   localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [b2yuv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [b2yuv_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [b2yuv_pkg::PIX_W-1:0]           req_blue,
   input  logic [b2yuv_pkg::PIX_W-1:0]           req_green,
   input  logic [b2yuv_pkg::PIX_W-1:0]           req_red,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output b2yuv_pkg::pixel_type                  push_pixel,
   output b2yuv_pkg::ctrl_type                   push_ctrl,
   output logic [SLOT_W-1:0]                     push_slot
);

   import b2yuv_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WSZ_W = $clog2(MAX_WIDTH + 1);
   localparam int HSZ_W = $clog2(MAX_HEIGHT + 1);

   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [WSZ_W-1:0]      width_eff;
   logic [HSZ_W-1:0]      height_eff;
   logic                  last_col;
   logic                  last_row;
   logic                  pair_done;
   logic                  accept;

   // Sizes of zero act as one; sizes beyond the maximum act as the maximum.
   always_comb begin
      if (width_ff == '0) begin
         width_eff = WSZ_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         width_eff = WSZ_W'(MAX_WIDTH);
      end else begin
         width_eff = WSZ_W'(width_ff);
      end
      if (height_ff == '0) begin
         height_eff = HSZ_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         height_eff = HSZ_W'(MAX_HEIGHT);
      end else begin
         height_eff = HSZ_W'(height_ff);
      end
   end

   assign last_col  = (WSZ_W'(col_ff) + WSZ_W'(1)) >= width_eff;
   assign last_row  = (HSZ_W'(row_ff) + HSZ_W'(1)) >= height_eff;
   assign pair_done = col_ff[0] || last_col;

   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   assign push_pixel.blue  = req_blue;
   assign push_pixel.green = req_green;
   assign push_pixel.red   = req_red;

   // An even row parks its pair sums unless it is the last row; every other
   // completed pair finishes a block.
   always_comb begin
      push_ctrl.frame_end     = last_col && last_row;
      push_ctrl.store_wr      = pair_done && !row_ff[0] && !last_row;
      push_ctrl.emit          = pair_done && (row_ff[0] || last_row);
      push_ctrl.use_store     = row_ff[0];
      push_ctrl.odd_col       = col_ff[0];
      push_ctrl.chroma_shift  = {1'b0, col_ff[0]} + {1'b0, row_ff[0]};
      push_ctrl.chroma_column = CHROMA_IDX_W'(col_ff >> 1);
      push_ctrl.chroma_row    = CHROMA_IDX_W'(row_ff >> 1);
   end

   assign push_slot = SLOT_W'(col_ff >> 1);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

>>> hdl/b2yuv_queue.sv
// ----------------------------------------------------------------------------
// b2yuv_queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module b2yuv_queue #(
   parameter  int DATA_W = 64,
   parameter  int DEPTH  = 2,
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/b2yuv_back.sv
// ----------------------------------------------------------------------------
// b2yuv_back
// Color arithmetic, 2x2 chroma accumulation through the line store, and the
// result register.
// ----------------------------------------------------------------------------
module b2yuv_back #(
   parameter  int MAX_WIDTH  = 4096,
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2,
   localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  pop_valid,
   output logic                                  pop_ready,
   input  b2yuv_pkg::pixel_type                  pop_pixel,
   input  b2yuv_pkg::ctrl_type                   pop_ctrl,
   input  logic [SLOT_W-1:0]                     pop_slot,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [b2yuv_pkg::PIX_W-1:0]           rsp_luma,
   output logic                                  rsp_chroma_valid,
   output logic [b2yuv_pkg::PIX_W-1:0]           rsp_chroma_u,
   output logic [b2yuv_pkg::PIX_W-1:0]           rsp_chroma_v,
   output logic [b2yuv_pkg::CHROMA_IDX_W-1:0]    rsp_chroma_column,
   output logic [b2yuv_pkg::CHROMA_IDX_W-1:0]    rsp_chroma_row,
   output logic                                  rsp_frame_end
);

   import b2yuv_pkg::*;

   // Stage one: products and sums.
   logic                     s1_valid_ff;
   logic [PIX_W-1:0]         s1_luma_ff, s1_luma_in;
   logic signed [PROD_W-1:0] s1_su_ff, s1_su_in;
   logic signed [PROD_W-1:0] s1_sv_ff, s1_sv_in;
   ctrl_type                 s1_ctrl_ff;
   logic [SLOT_W-1:0]        s1_slot_ff;

   // Stage two: clamped chroma, line store data arrives.
   logic                     s2_valid_ff;
   logic [PIX_W-1:0]         s2_luma_ff;
   logic [PIX_W-1:0]         s2_u_ff;
   logic [PIX_W-1:0]         s2_v_ff;
   ctrl_type                 s2_ctrl_ff;
   logic [SLOT_W-1:0]        s2_slot_ff;

   logic                     byp_ff, byp_in;
   logic [ENTRY_W-1:0]       byp_data_ff;
   logic [SUM_W-1:0]         pair_u_ff, pair_u_in;
   logic [SUM_W-1:0]         pair_v_ff, pair_v_in;

   logic                     rsp_valid_ff;
   logic [PIX_W-1:0]         rsp_luma_ff;
   logic                     rsp_cvalid_ff;
   logic [PIX_W-1:0]         rsp_cu_ff, rsp_cu_in;
   logic [PIX_W-1:0]         rsp_cv_ff, rsp_cv_in;
   logic [CHROMA_IDX_W-1:0]  rsp_ccol_ff, rsp_ccol_in;
   logic [CHROMA_IDX_W-1:0]  rsp_crow_ff, rsp_crow_in;
   logic                     rsp_fend_ff;

   logic                     adv;
   logic                     ram_we;
   logic [ENTRY_W-1:0]       ram_wdata;
   logic [ENTRY_W-1:0]       ram_rdata;
   logic [ENTRY_W-1:0]       entry;
   logic [SUM_W:0]           sum_u;
   logic [SUM_W:0]           sum_v;
   int                       y_acc;
   int                       u_acc;
   int                       v_acc;

   // All stages move together whenever the result register is free or drained.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop_ready = adv;

   always_comb begin
      y_acc = Y_R * int'(pop_pixel.red) + Y_G * int'(pop_pixel.green)
            + Y_B * int'(pop_pixel.blue);
      u_acc = CHROMA_OFFSET - U_R * int'(pop_pixel.red) - U_G * int'(pop_pixel.green)
            + U_B * int'(pop_pixel.blue);
      v_acc = CHROMA_OFFSET + V_R * int'(pop_pixel.red) - V_G * int'(pop_pixel.green)
            - V_B * int'(pop_pixel.blue);
      s1_luma_in = PIX_W'(y_acc >> FRAC_BITS);
      s1_su_in   = PROD_W'(u_acc);
      s1_sv_in   = PROD_W'(v_acc);
   end

   // The pair sums of an even column start a new pair; an odd column adds to it.
   always_comb begin
      pair_u_in = s2_ctrl_ff.odd_col ? pair_u_ff + SUM_W'(s2_u_ff) : SUM_W'(s2_u_ff);
      pair_v_in = s2_ctrl_ff.odd_col ? pair_v_ff + SUM_W'(s2_v_ff) : SUM_W'(s2_v_ff);
   end

   // The entry written by the item just ahead is forwarded past the RAM.
   assign entry = byp_ff ? byp_data_ff : ram_rdata;

   always_comb begin
      sum_u = {1'b0, pair_u_in};
      sum_v = {1'b0, pair_v_in};
      if (s2_ctrl_ff.use_store) begin
         sum_u = sum_u + {1'b0, entry[SUM_W-1:0]};
         sum_v = sum_v + {1'b0, entry[ENTRY_W-1:SUM_W]};
      end
      if (s2_ctrl_ff.emit) begin
         rsp_cu_in   = PIX_W'(sum_u >> s2_ctrl_ff.chroma_shift);
         rsp_cv_in   = PIX_W'(sum_v >> s2_ctrl_ff.chroma_shift);
         rsp_ccol_in = s2_ctrl_ff.chroma_column;
         rsp_crow_in = s2_ctrl_ff.chroma_row;
      end else begin
         rsp_cu_in   = '0;
         rsp_cv_in   = '0;
         rsp_ccol_in = '0;
         rsp_crow_in = '0;
      end
   end

   assign ram_we    = adv && s2_valid_ff && s2_ctrl_ff.store_wr;
   assign ram_wdata = {pair_v_in, pair_u_in};
   assign byp_in    = ram_we && (s2_slot_ff == s1_slot_ff);

   b2yuv_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (s2_slot_ff),
      .wdata (ram_wdata),
      .re    (adv),
      .raddr (s1_slot_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
         pair_u_ff    <= '0;
         pair_v_ff    <= '0;
      end else if (adv) begin
         s1_valid_ff  <= pop_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
         byp_ff       <= byp_in;
         if (s2_valid_ff) begin
            pair_u_ff <= pair_u_in;
            pair_v_ff <= pair_v_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_luma_ff    <= s1_luma_in;
         s1_su_ff      <= s1_su_in;
         s1_sv_ff      <= s1_sv_in;
         s1_ctrl_ff    <= pop_ctrl;
         s1_slot_ff    <= pop_slot;
         s2_luma_ff    <= s1_luma_ff;
         s2_u_ff       <= clamp_byte(s1_su_ff);
         s2_v_ff       <= clamp_byte(s1_sv_ff);
         s2_ctrl_ff    <= s1_ctrl_ff;
         s2_slot_ff    <= s1_slot_ff;
         byp_data_ff   <= ram_wdata;
         rsp_luma_ff   <= s2_luma_ff;
         rsp_cvalid_ff <= s2_ctrl_ff.emit;
         rsp_cu_ff     <= rsp_cu_in;
         rsp_cv_ff     <= rsp_cv_in;
         rsp_ccol_ff   <= rsp_ccol_in;
         rsp_crow_ff   <= rsp_crow_in;
         rsp_fend_ff   <= s2_ctrl_ff.frame_end;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_luma          = rsp_luma_ff;
   assign rsp_chroma_valid  = rsp_cvalid_ff;
   assign rsp_chroma_u      = rsp_cu_ff;
   assign rsp_chroma_v      = rsp_cv_ff;
   assign rsp_chroma_column = rsp_ccol_ff;
   assign rsp_chroma_row    = rsp_crow_ff;
   assign rsp_frame_end     = rsp_fend_ff;

endmodule

>>> hdl/bgr_to_yuv420_converter_top.sv
// ----------------------------------------------------------------------------
// bgr_to_yuv420_converter_top
// BGR pixel stream to per-pixel luma and 2x2-averaged 4:2:0 chroma.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the req_ channel, one beat per pixel. Each
// pixel gives exactly one rsp_ beat carrying its luma; the beat of the last
// present pixel of a 2x2 block also carries the block's averaged U and V and
// its position in the chroma plane, and the last pixel of a frame raises
// rsp_frame_end. Frame size comes from the csr_ port and may be written while
// no pixel is in flight.
// An accepted req_ beat passes the input queue, the multiply stage, the
// clamp stage that reads the line store, then the chroma stage that writes
// the line store and fills the result register. One pixel per cycle is
// sustained while rsp_ready is high; the single write port and single read
// port of the line store carry one pair sum each per cycle.
// Reset sets the frame size to 640 by 480 and the position to the first
// pixel; the line store is not cleared, since every entry is written on an
// even row before the odd row below reads it. When the receiver stalls, the
// result beat holds and the input queue keeps taking up to two more pixels.
// ----------------------------------------------------------------------------
module bgr_to_yuv420_converter_top #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [b2yuv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [b2yuv_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [b2yuv_pkg::PIX_W-1:0]           req_blue,
   input  logic [b2yuv_pkg::PIX_W-1:0]           req_green,
   input  logic [b2yuv_pkg::PIX_W-1:0]           req_red,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [b2yuv_pkg::PIX_W-1:0]           rsp_luma,
   output logic                                  rsp_chroma_valid,
   output logic [b2yuv_pkg::PIX_W-1:0]           rsp_chroma_u,
   output logic [b2yuv_pkg::PIX_W-1:0]           rsp_chroma_v,
   output logic [b2yuv_pkg::CHROMA_IDX_W-1:0]    rsp_chroma_column,
   output logic [b2yuv_pkg::CHROMA_IDX_W-1:0]    rsp_chroma_row,
   output logic                                  rsp_frame_end
);

   import b2yuv_pkg::*;

   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int QDATA_W    = SLOT_W + $bits(ctrl_type) + $bits(pixel_type);
   localparam int QDEPTH     = 2;

   logic                push_valid;
   logic                push_ready;
   pixel_type           push_pixel;
   ctrl_type            push_ctrl;
   logic [SLOT_W-1:0]   push_slot;
   logic                pop_valid;
   logic                pop_ready;
   logic [QDATA_W-1:0]  pop_data;
   pixel_type           pop_pixel;
   ctrl_type            pop_ctrl;
   logic [SLOT_W-1:0]   pop_slot;

   b2yuv_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_blue   (req_blue),
      .req_green  (req_green),
      .req_red    (req_red),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_pixel (push_pixel),
      .push_ctrl  (push_ctrl),
      .push_slot  (push_slot)
   );

   b2yuv_queue #(
      .DATA_W (QDATA_W),
      .DEPTH  (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_slot, push_ctrl, push_pixel}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_slot, pop_ctrl, pop_pixel} = pop_data;

   b2yuv_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_pixel         (pop_pixel),
      .pop_ctrl          (pop_ctrl),
      .pop_slot          (pop_slot),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_luma          (rsp_luma),
      .rsp_chroma_valid  (rsp_chroma_valid),
      .rsp_chroma_u      (rsp_chroma_u),
      .rsp_chroma_v      (rsp_chroma_v),
      .rsp_chroma_column (rsp_chroma_column),
      .rsp_chroma_row    (rsp_chroma_row),
      .rsp_frame_end     (rsp_frame_end)
   );

endmodule

>>> hdl/b2yuv_checker.sv
// ----------------------------------------------------------------------------
// b2yuv_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b2yuv_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [b2yuv_pkg::PIX_W-1:0]           rsp_luma,
   input logic                                  rsp_chroma_valid,
   input logic [b2yuv_pkg::PIX_W-1:0]           rsp_chroma_u,
   input logic [b2yuv_pkg::PIX_W-1:0]           rsp_chroma_v,
   input logic [b2yuv_pkg::CHROMA_IDX_W-1:0]    rsp_chroma_column,
   input logic [b2yuv_pkg::CHROMA_IDX_W-1:0]    rsp_chroma_row,
   input logic                                  rsp_frame_end
);

   // A stalled result beat keeps its luma.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_luma),
      "stalled result beat changed")

   // Without a finished block every chroma field reads zero.
   `ASSERT_CLK_RST(a_chroma_zero, clock, reset,
      rsp_valid && !rsp_chroma_valid |-> rsp_chroma_u == '0 && rsp_chroma_v == '0
         && rsp_chroma_column == '0 && rsp_chroma_row == '0,
      "chroma fields set without a finished block")

   // The last pixel of a frame always closes a block.
   `ASSERT_CLK_RST(a_frame_end_chroma, clock, reset,
      rsp_valid && rsp_frame_end |-> rsp_chroma_valid, "frame end without chroma")

   // Nothing is offered right after reset.
   `ASSERT_CLK(a_reset_idle, clock, reset |=> !rsp_valid, "result offered after reset")

endmodule

bind bgr_to_yuv420_converter_top b2yuv_checker u_b2yuv_checker (.*);

>>> tb/bgr_to_yuv420_converter_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bgr_to_yuv420_converter_top_test
// Self-checking bench for the BGR to YUV 4:2:0 converter. Pixels go in as
// whole frames of many sizes. A local copy of the frame position, pair sums and
// chroma line store predicts each output beat, and every beat is compared with
// that prediction field by field. Both handshakes stall at random, and the
// frame size is also changed in the middle of a frame.
// ----------------------------------------------------------------------------
module bgr_to_yuv420_converter_top_test;
   import b2yuv_pkg::*;

   localparam int MAX_SIZE     = 4096;
   localparam int LIMIT_CYCLES = 500000;

   // BT.601 weights in Q0.16.
   localparam int LUMA_R      = 19595;
   localparam int LUMA_G      = 38470;
   localparam int LUMA_B      = 7471;
   localparam int CB_R        = 11076;
   localparam int CB_G        = 21692;
   localparam int CB_B        = 32702;
   localparam int CR_R        = 32702;
   localparam int CR_G        = 27460;
   localparam int CR_B        = 5308;
   localparam int CHROMA_BIAS = 128 * 65536;

   typedef struct packed {
      logic [PIX_W-1:0]        luma;
      logic                    chroma_valid;
      logic [PIX_W-1:0]        chroma_u;
      logic [PIX_W-1:0]        chroma_v;
      logic [CHROMA_IDX_W-1:0] chroma_column;
      logic [CHROMA_IDX_W-1:0] chroma_row;
      logic                    frame_end;
   } yuv_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [PIX_W-1:0]        req_blue = '0;
   logic [PIX_W-1:0]        req_green = '0;
   logic [PIX_W-1:0]        req_red = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [PIX_W-1:0]        rsp_luma;
   logic                    rsp_chroma_valid;
   logic [PIX_W-1:0]        rsp_chroma_u;
   logic [PIX_W-1:0]        rsp_chroma_v;
   logic [CHROMA_IDX_W-1:0] rsp_chroma_column;
   logic [CHROMA_IDX_W-1:0] rsp_chroma_row;
   logic                    rsp_frame_end;

   // Local copy of the converter's registers and position.
   logic [CSR_DATA_W-1:0] frame_width = WIDTH_RESET;
   logic [CSR_DATA_W-1:0] frame_height = HEIGHT_RESET;
   logic [11:0]           column_pos = '0;
   logic [11:0]           row_pos = '0;
   logic [SUM_W-1:0]      pair_sum_u = '0;
   logic [SUM_W-1:0]      pair_sum_v = '0;
   logic [ENTRY_W-1:0]    line_sums [0:2047];

   yuv_result_type pending_results [$];
   int          error_count = 0;
   int          cycle_count = 0;
   int unsigned pixels_sent = 0;
   int          sender_idle_pct = 0;
   int          receiver_idle_pct = 0;
   bit          frame_closed = 1'b0;

   bgr_to_yuv420_converter_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_blue          (req_blue),
      .req_green         (req_green),
      .req_red           (req_red),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_luma          (rsp_luma),
      .rsp_chroma_valid  (rsp_chroma_valid),
      .rsp_chroma_u      (rsp_chroma_u),
      .rsp_chroma_v      (rsp_chroma_v),
      .rsp_chroma_column (rsp_chroma_column),
      .rsp_chroma_row    (rsp_chroma_row),
      .rsp_frame_end     (rsp_frame_end)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= receiver_idle_pct);
   end

   function automatic int unsigned effective_size(input logic [CSR_DATA_W-1:0] value);
      if (value == '0) begin
         return 1;
      end
      return (value > MAX_SIZE) ? MAX_SIZE : value;
   endfunction

   function automatic int unsigned clip_to_byte(input int s);
      if (s <= 0) begin
         return 0;
      end
      return ((s >> 16) > 255) ? 255 : (s >> 16);
   endfunction

   // Works out the beat for one pixel and advances the frame position.
   function automatic yuv_result_type convert_pixel(input pixel_type px);
      yuv_result_type res;
      int          r, g, b;
      int unsigned w, h, col, row, u, v, su, sv, shift, slot;
      bit          last_col, last_row;
      r = px.red;
      g = px.green;
      b = px.blue;
      w = effective_size(frame_width);
      h = effective_size(frame_height);
      col = column_pos;
      row = row_pos;
      last_col = (col + 1 >= w);
      last_row = (row + 1 >= h);
      res = '0;
      res.luma = PIX_W'((LUMA_R * r + LUMA_G * g + LUMA_B * b) >> 16);
      u = clip_to_byte(CB_B * b - CB_R * r - CB_G * g + CHROMA_BIAS);
      v = clip_to_byte(CR_R * r - CR_G * g - CR_B * b + CHROMA_BIAS);
      if ((col & 1) == 0) begin
         pair_sum_u = SUM_W'(u);
         pair_sum_v = SUM_W'(v);
      end else begin
         pair_sum_u = pair_sum_u + SUM_W'(u);
         pair_sum_v = pair_sum_v + SUM_W'(v);
      end
      if (((col & 1) != 0) || last_col) begin
         slot = col >> 1;
         if (((row & 1) == 0) && !last_row) begin
            line_sums[slot] = {pair_sum_v, pair_sum_u};
         end else begin
            su = pair_sum_u;
            sv = pair_sum_v;
            shift = col & 1;
            // An odd row closes the block with the pair sums saved on the row above.
            if ((row & 1) != 0) begin
               su += line_sums[slot][SUM_W-1:0];
               sv += line_sums[slot][ENTRY_W-1:SUM_W];
               shift++;
            end
            res.chroma_valid = 1'b1;
            res.chroma_u = PIX_W'(su >> shift);
            res.chroma_v = PIX_W'(sv >> shift);
            res.chroma_column = CHROMA_IDX_W'(col >> 1);
            res.chroma_row = CHROMA_IDX_W'(row >> 1);
         end
      end
      res.frame_end = last_col && last_row;
      if (last_col) begin
         column_pos = '0;
         row_pos = last_row ? 12'd0 : 12'(row + 1);
      end else begin
         column_pos = 12'(col + 1);
      end
      return res;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      logic [PIX_W-1:0] comp [3];
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(7))
            0: begin
               comp[i] = '0;
            end
            1: begin
               comp[i] = '1;
            end
            default: begin
               comp[i] = PIX_W'($urandom_range(255));
            end
         endcase
      end
      px.blue = comp[0];
      px.green = comp[1];
      px.red = comp[2];
      return px;
   endfunction

   task automatic check_field(input string field_name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $error("%s: expected %0d, got %0d", field_name, want, got);
      end
   endtask

   always @(posedge clock) begin
      yuv_result_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $error("result beat with no pixel waiting for it");
         end else begin
            expected = pending_results.pop_front();
            check_field("luma", expected.luma, rsp_luma);
            check_field("chroma_valid", expected.chroma_valid, rsp_chroma_valid);
            check_field("chroma_u", expected.chroma_u, rsp_chroma_u);
            check_field("chroma_v", expected.chroma_v, rsp_chroma_v);
            check_field("chroma_column", expected.chroma_column, rsp_chroma_column);
            check_field("chroma_row", expected.chroma_row, rsp_chroma_row);
            check_field("frame_end", expected.frame_end, rsp_frame_end);
         end
      end
   end

   task automatic send_pixel(input pixel_type px);
      yuv_result_type expected;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_blue = px.blue;
      req_green = px.green;
      req_red = px.red;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      expected = convert_pixel(px);
      pending_results.push_back(expected);
      frame_closed = expected.frame_end;
      pixels_sent++;
   endtask

   task automatic finish_frame();
      do begin
         send_pixel(random_pixel());
      end while (!frame_closed);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      if (index == CSR_IMAGE_WIDTH) begin
         frame_width = value;
      end else begin
         frame_height = value;
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Both registers are written only once nothing is in flight.
   task automatic set_frame_size(input int unsigned width, input int unsigned height);
      wait_until_drained();
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(width));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(height));
   endtask

   // Runs part of a row at the reset size, then shrinks the frame to one row of
   // eight while the row is under way so that it ends there.
   task automatic reset_default_test();
      repeat (6) send_pixel(random_pixel());
      set_frame_size(8, 1);
      finish_frame();
   endtask

   // A 3x3 frame gives blocks of four, two and one pixel. Colors are packed as
   // blue, green, red from the top byte down.
   task automatic extreme_pixel_test();
      logic [23:0] color_list [9] = '{24'h000000, 24'hFFFFFF, 24'hFF0000,
                                      24'h00FF00, 24'h0000FF, 24'h00FFFF,
                                      24'hFFFF00, 24'hFF00FF, 24'h55AA55};
      set_frame_size(3, 3);
      foreach (color_list[i]) begin
         send_pixel(pixel_type'(color_list[i]));
      end
   endtask

   // Sizes of zero and above the maximum, and the maximum itself, each cut
   // short by a new size written mid-frame, then a frame of zero height.
   task automatic size_clamp_test();
      set_frame_size(0, 8191);
      repeat (5) send_pixel(random_pixel());
      set_frame_size(0, 4);
      finish_frame();
      set_frame_size(8191, 1);
      repeat (4) send_pixel(random_pixel());
      set_frame_size(6, 1);
      finish_frame();
      set_frame_size(MAX_SIZE, MAX_SIZE);
      repeat (2) send_pixel(random_pixel());
      set_frame_size(4, 1);
      finish_frame();
      set_frame_size(2, 0);
      finish_frame();
   endtask

   // Two wide rows carry pair sums through many line store entries.
   task automatic wide_frame_test();
      set_frame_size(80, 2);
      finish_frame();
   endtask

   task automatic random_frames_test(input int sender_pct, input int receiver_pct,
                                     input int unsigned pixel_budget);
      int unsigned start_count, width, height, pixel_total, cut;
      sender_idle_pct = sender_pct;
      receiver_idle_pct = receiver_pct;
      start_count = pixels_sent;
      while (pixels_sent - start_count < pixel_budget) begin
         if ($urandom_range(9) == 0) begin
            width = $urandom_range(13, 64);
            height = $urandom_range(1, 4);
         end else begin
            width = $urandom_range(0, 12);
            height = $urandom_range(0, 8);
         end
         set_frame_size(width, height);
         pixel_total = effective_size(width) * effective_size(height);
         if (pixel_total > 1 && $urandom_range(5) == 0) begin
            cut = $urandom_range(1, pixel_total - 1);
            repeat (cut) send_pixel(random_pixel());
            // The width stays put; a height at or under the current row ends the
            // frame with this row.
            set_frame_size(width, $urandom_range(0, 8));
         end
         finish_frame();
      end
   endtask

   initial begin
      foreach (line_sums[i]) begin
         line_sums[i] = '0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      sender_idle_pct = 26;
      receiver_idle_pct = 67;
      reset_default_test();
      extreme_pixel_test();
      size_clamp_test();
      wide_frame_test();
      random_frames_test(26, 67, 370);
      random_frames_test(67, 26, 370);
      random_frames_test(0, 0, 370);
      wait_until_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/b2yuv_pkg.sv
hdl/b2yuv_ram.sv
hdl/b2yuv_front.sv
hdl/b2yuv_queue.sv
hdl/b2yuv_back.sv
hdl/bgr_to_yuv420_converter_top.sv
hdl/b2yuv_checker.sv
tb/bgr_to_yuv420_converter_top_test.sv
